// ----- src/rcpa_pkg.sv -----
// Shared types and constants of the refcounted chunk page allocator.
// No dependencies.
package rcpa_pkg;
   localparam int THREADS_DEF = 16;
   localparam int CHUNK_SLOTS_DEF = 64;
   localparam int PAGES_DEF = 512;

   localparam int OP_W = 2;
   localparam int TID_W = 4;
   localparam int CNT_W = 9;
   localparam int SLOT_W = 6;
   localparam int PIDX_W = 9;
   localparam int STAT_W = 3;
   localparam int USED_W = 7;

   typedef enum logic [OP_W-1:0] {
      OP_INIT = 2'd0,
      OP_GET = 2'd1,
      OP_PUT = 2'd2,
      OP_LOOKUP = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK = 3'd0,
      ST_BAD_COUNT = 3'd1,
      ST_NOT_INIT = 3'd2,
      ST_BAD_PAGE = 3'd3,
      ST_POOL_FULL = 3'd4
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic busy;
   } stat_type;
endpackage

// ----- src/rcpa_ctrl.sv -----
// Handshake controller of the chunk allocator: accept, compute, deliver.
// Depends on rcpa_pkg.
module rcpa_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rcpa_pkg::cmd_type cmd
);
   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_type;
   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign cmd.capture = (state_ff == S_IDLE) && req_valid;
   assign cmd.commit = (state_ff == S_EXEC);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_EXEC;
         S_EXEC: state_in = S_OUT;
         S_OUT: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   a_out_after_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |=> state_ff == S_OUT) else $error("exec not followed by out");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accepting while result pending");
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
endmodule

// ----- src/rcpa_dp.sv -----
// Datapath of the chunk allocator: thread and slot tables and result register.
// Depends on rcpa_pkg.
module rcpa_dp #(
   parameter int THREADS = rcpa_pkg::THREADS_DEF,
   parameter int CHUNK_SLOTS = rcpa_pkg::CHUNK_SLOTS_DEF,
   parameter int PAGES = rcpa_pkg::PAGES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  rcpa_pkg::cmd_type cmd,
   input  logic [rcpa_pkg::OP_W-1:0] req_op,
   input  logic [rcpa_pkg::TID_W-1:0] req_thread_id,
   input  logic [rcpa_pkg::CNT_W-1:0] req_page_count,
   input  logic [rcpa_pkg::SLOT_W-1:0] req_chunk_slot,
   input  logic [rcpa_pkg::PIDX_W-1:0] req_page_index,
   output logic [rcpa_pkg::STAT_W-1:0] rsp_status,
   output logic [rcpa_pkg::SLOT_W-1:0] rsp_out_slot,
   output logic [rcpa_pkg::PIDX_W-1:0] rsp_start_page,
   output logic rsp_chunk_freed,
   output logic [rcpa_pkg::USED_W-1:0] rsp_chunks_used
);
   localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int SW = $clog2(CHUNK_SLOTS);
   localparam int PW = $clog2(PAGES) + 1;   // bump pointer, may reach PAGES
   // A thread whose chunk was freed and then reused keeps adding to it, so a
   // count can reach one producer reference plus nearly a chunk per thread.
   localparam int RW = $clog2(THREADS * PAGES + 1);
   localparam int MW = PW + RW;
   localparam int UW = $clog2(CHUNK_SLOTS + 1);

   logic [THREADS-1:0] t_ready_ff;
   logic [SW-1:0] t_chunk_ff [THREADS];
   logic [PW-1:0] t_next_ff [THREADS];
   logic [CHUNK_SLOTS-1:0] s_valid_ff;
   // Slot table: high-water mark above the reference count, registered read.
   logic [MW-1:0] s_tab [CHUNK_SLOTS];
   logic [MW-1:0] tab_q_ff;
   logic [UW-1:0] used_ff;

   // Registered request fields and the free-slot search result.
   logic [rcpa_pkg::OP_W-1:0] op_ff;
   logic [rcpa_pkg::TID_W-1:0] tid_ff;
   logic [rcpa_pkg::CNT_W-1:0] cnt_ff;
   logic [rcpa_pkg::SLOT_W-1:0] slot_ff;
   logic [rcpa_pkg::PIDX_W-1:0] pidx_ff;
   logic found_ff;
   logic [SW-1:0] free_ff;

   // Release of the old slot on a chunk swap, written in the cycle after.
   logic wb_ff;
   logic [SW-1:0] wb_addr_ff;
   logic [MW-1:0] wb_data_ff;

   logic found_c;
   logic [SW-1:0] free_c;
   always_comb begin
      found_c = 1'b0;
      free_c = '0;
      if (used_ff < UW'(CHUNK_SLOTS)) begin
         found_c = 1'b1;
         free_c = used_ff[SW-1:0];
      end else begin
         for (int i = CHUNK_SLOTS - 1; i >= 0; i--) begin
            if (!s_valid_ff[i]) begin
               found_c = 1'b1;
               free_c = SW'(i);
            end
         end
      end
   end

   logic [rcpa_pkg::STAT_W-1:0] st_ff;
   logic [rcpa_pkg::SLOT_W-1:0] os_ff;
   logic [rcpa_pkg::PIDX_W-1:0] sp_ff;
   logic fr_ff;

   logic t_ok, s_ok;
   logic [TW-1:0] ti;
   logic [SW-1:0] si, cur;
   logic cur_ok, swap;
   logic [PW:0] endp;
   logic [PW-1:0] start;
   logic [RW-1:0] ref_q, ref_dec;
   logic [PW-1:0] high_q;
   logic last_ref, init_claim, get_ok, put_ok;
   logic [SW-1:0] tab_ra;
   always_comb begin
      ti = TW'(tid_ff);
      si = SW'(slot_ff);
      t_ok = 32'(tid_ff) < THREADS;
      s_ok = 32'(slot_ff) < CHUNK_SLOTS && 32'(pidx_ff) < PAGES && s_valid_ff[si];
      cur = t_chunk_ff[ti];
      cur_ok = s_valid_ff[cur];
      endp = (PW+1)'(t_next_ff[ti]) + (PW+1)'(cnt_ff);
      swap = !cur_ok || endp > (PW+1)'(PAGES);
      start = swap ? PW'(1) : t_next_ff[ti];
      ref_q = tab_q_ff[RW-1:0];
      high_q = tab_q_ff[MW-1:RW];
      ref_dec = (ref_q > RW'(0)) ? ref_q - RW'(1) : ref_q;
      last_ref = ref_q <= RW'(1);
      init_claim = op_ff == rcpa_pkg::OP_INIT && t_ok && !t_ready_ff[ti] && found_ff;
      get_ok = op_ff == rcpa_pkg::OP_GET && t_ok && cnt_ff != '0
               && 32'(cnt_ff) <= PAGES - 1 && t_ready_ff[ti] && !(swap && !found_ff);
      put_ok = op_ff == rcpa_pkg::OP_PUT && s_ok;
      // A get reads its thread's current slot, a put or lookup the named slot.
      tab_ra = (req_op == rcpa_pkg::OP_GET) ? t_chunk_ff[TW'(req_thread_id)]
                                            : SW'(req_chunk_slot);
   end

   logic tab_we;
   logic [SW-1:0] tab_wa;
   logic [MW-1:0] tab_wd;
   always_comb begin
      tab_we = 1'b0;
      tab_wa = '0;
      tab_wd = '0;
      if (wb_ff) begin
         tab_we = 1'b1;
         tab_wa = wb_addr_ff;
         tab_wd = wb_data_ff;
      end else if (cmd.commit) begin
         if (init_claim) begin
            tab_we = 1'b1;
            tab_wa = free_ff;
            tab_wd = {PW'(1), RW'(1)};
         end else if (get_ok && swap) begin
            tab_we = 1'b1;
            tab_wa = free_ff;
            tab_wd = {PW'(1) + PW'(cnt_ff), RW'(1) + RW'(cnt_ff)};
         end else if (get_ok) begin
            tab_we = 1'b1;
            tab_wa = cur;
            tab_wd = {(endp[PW-1:0] > high_q) ? endp[PW-1:0] : high_q,
                      ref_q + RW'(cnt_ff)};
         end else if (put_ok) begin
            tab_we = 1'b1;
            tab_wa = si;
            tab_wd = {high_q, ref_dec};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tab_we) s_tab[tab_wa] <= tab_wd;
      if (cmd.capture) tab_q_ff <= s_tab[tab_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) wb_ff <= 1'b0;
      else wb_ff <= cmd.commit && get_ok && swap && cur_ok;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         wb_addr_ff <= cur;
         wb_data_ff <= {high_q, ref_dec};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_op;
         tid_ff <= req_thread_id;
         cnt_ff <= req_page_count;
         slot_ff <= req_chunk_slot;
         pidx_ff <= req_page_index;
         found_ff <= found_c;
         free_ff <= free_c;
      end
      if (cmd.commit) begin
         st_ff <= rcpa_pkg::ST_OK;
         os_ff <= '0;
         sp_ff <= '0;
         fr_ff <= 1'b0;
         case (rcpa_pkg::op_type'(op_ff))
            rcpa_pkg::OP_INIT: begin
               if (!t_ok) st_ff <= rcpa_pkg::ST_NOT_INIT;
               else if (t_ready_ff[ti]) os_ff <= rcpa_pkg::SLOT_W'(cur);
               else if (!found_ff) st_ff <= rcpa_pkg::ST_POOL_FULL;
               else os_ff <= rcpa_pkg::SLOT_W'(free_ff);
            end
            rcpa_pkg::OP_GET: begin
               if (!t_ok) st_ff <= rcpa_pkg::ST_NOT_INIT;
               else if (cnt_ff == '0 || 32'(cnt_ff) > PAGES - 1)
                  st_ff <= rcpa_pkg::ST_BAD_COUNT;
               else if (!t_ready_ff[ti]) st_ff <= rcpa_pkg::ST_NOT_INIT;
               else if (swap && !found_ff) st_ff <= rcpa_pkg::ST_POOL_FULL;
               else begin
                  os_ff <= rcpa_pkg::SLOT_W'(swap ? free_ff : cur);
                  sp_ff <= rcpa_pkg::PIDX_W'(start);
                  fr_ff <= swap && cur_ok && last_ref;
               end
            end
            default: begin
               if (!s_ok) st_ff <= rcpa_pkg::ST_BAD_PAGE;
               else begin
                  os_ff <= slot_ff;
                  if (op_ff == rcpa_pkg::OP_PUT) fr_ff <= last_ref;
               end
            end
         endcase
      end
   end

   // Thread tables; entries are written only on claim or grant.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (init_claim) begin
            t_chunk_ff[ti] <= free_ff;
            t_next_ff[ti] <= PW'(1);
         end else if (get_ok) begin
            t_next_ff[ti] <= start + PW'(cnt_ff);
            if (swap) t_chunk_ff[ti] <= free_ff;
         end
      end
   end

   // Control state with reset: ready bits, valid bits, used count.
   always_ff @(posedge clock) begin
      if (reset) begin
         t_ready_ff <= '0;
         s_valid_ff <= '0;
         used_ff <= '0;
      end else if (cmd.commit) begin
         if (init_claim) begin
            t_ready_ff[ti] <= 1'b1;
            s_valid_ff[free_ff] <= 1'b1;
            if (UW'(free_ff) == used_ff) used_ff <= used_ff + UW'(1);
         end else if (get_ok && swap) begin
            if (cur_ok && last_ref) s_valid_ff[cur] <= 1'b0;
            s_valid_ff[free_ff] <= 1'b1;
            if (UW'(free_ff) == used_ff && used_ff < UW'(CHUNK_SLOTS))
               used_ff <= used_ff + UW'(1);
         end else if (put_ok && last_ref) begin
            s_valid_ff[si] <= 1'b0;
         end
      end
   end

   assign rsp_status = st_ff;
   assign rsp_out_slot = os_ff;
   assign rsp_start_page = sp_ff;
   assign rsp_chunk_freed = fr_ff;
   assign rsp_chunks_used = rcpa_pkg::USED_W'(used_ff);

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(CHUNK_SLOTS)) else $error("used count overflow");
   a_used_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> used_ff >= $past(used_ff)) else $error("used count fell");
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      st_ff != rcpa_pkg::ST_OK && !cmd.commit |-> os_ff == '0 && !fr_ff)
      else $error("error result carries data");
   a_wb_alone: assert property (@(posedge clock) disable iff (reset)
      wb_ff |-> !cmd.commit && !cmd.capture) else $error("table write collision");
endmodule

// ----- src/refcounted_chunk_page_allocator.sv -----
// Top level of the refcounted chunk page allocator.
// Depends on rcpa_pkg, rcpa_ctrl and rcpa_dp.
//
// Every request gives exactly one result. When a request is accepted, it is
// registered, the slot table is read and a free slot is sought; then the
// thread and slot tables are updated and the result is registered (a chunk
// swap writes the released slot in the cycle after). The result register
// then holds until taken. The next request is accepted in the cycle after
// the result is taken, so no new request is taken while one is still in
// progress or its result is still pending on the result side.
module refcounted_chunk_page_allocator #(
   parameter int THREADS = rcpa_pkg::THREADS_DEF,
   parameter int CHUNK_SLOTS = rcpa_pkg::CHUNK_SLOTS_DEF,
   parameter int PAGES_PER_CHUNK = rcpa_pkg::PAGES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [rcpa_pkg::OP_W-1:0] req_op,
   input  logic [rcpa_pkg::TID_W-1:0] req_thread_id,
   input  logic [rcpa_pkg::CNT_W-1:0] req_page_count,
   input  logic [rcpa_pkg::SLOT_W-1:0] req_chunk_slot,
   input  logic [rcpa_pkg::PIDX_W-1:0] req_page_index,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [rcpa_pkg::STAT_W-1:0] rsp_status,
   output logic [rcpa_pkg::SLOT_W-1:0] rsp_out_slot,
   output logic [rcpa_pkg::PIDX_W-1:0] rsp_start_page,
   output logic rsp_chunk_freed,
   output logic [rcpa_pkg::USED_W-1:0] rsp_chunks_used
);
   rcpa_pkg::cmd_type cmd;

   rcpa_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .cmd
   );

   rcpa_dp #(
      .THREADS(THREADS), .CHUNK_SLOTS(CHUNK_SLOTS), .PAGES(PAGES_PER_CHUNK)
   ) u_dp (
      .clock, .reset, .cmd, .req_op, .req_thread_id, .req_page_count,
      .req_chunk_slot, .req_page_index, .rsp_status, .rsp_out_slot,
      .rsp_start_page, .rsp_chunk_freed, .rsp_chunks_used
   );
endmodule
